// ===== src/trsf_pkg.sv =====
// Shared constants and record types for the trace ring session filter.
package trsf_pkg;

  localparam int unsigned DEPTH  = 32;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = ADDR_W + 1;
  localparam int unsigned LIM_W  = 6;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_DUMP = 1'b1;

  localparam logic KIND_EVENT   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [63:0] session;
    logic [63:0] probe;
    logic [31:0] ev_type;
    logic [31:0] thread;
    logic [63:0] call;
    logic [63:0] time_ns;
  } trsf_event_t;

  typedef struct packed {
    logic             kind;
    trsf_event_t      ev;
    logic [LIM_W-1:0] match_count;
    logic [63:0]      drop_count;
    logic             last;
  } trsf_result_t;

endpackage

// ===== src/trsf_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module trsf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/trsf_out_reg.sv =====
// Output register that holds one result until the receiver takes it.
module trsf_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  trsf_pkg::trsf_result_t load_data,
  output logic                  ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output trsf_pkg::trsf_result_t out_data
);
  import trsf_pkg::*;

  logic         valid_r;
  logic         valid_nxt;
  trsf_result_t data_r;

  assign ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (ready) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== src/trace_ring_session_filter.sv =====
// Top level of the overwriting trace ring with a session-filtered dump.
//
// Input channel (in_*): one transfer per item. A push (in_cmd 0) stores the
// event in the ring and produces no result; pushes may arrive every cycle
// while in_stall is low. A dump (in_cmd 1) walks up to DEPTH newest slots,
// oldest first, and sends each event whose session matches, up to
// in_out_limit of them, followed by one summary transfer with out_last set.
// A dump holds in_stall high through a setup state, a read and a compare
// state per slot (the ring memory has a registered read port), and the
// summary state, until the summary is loaded into the output register.
// Result channel (out_*): a single output register. While out_stall is high
// the register holds a valid result, and the walk pauses at the next matching
// slot or at the summary. cfg_we writes the read position; it is to be written
// by the user only while the block is idle; the block does not enforce this.
// Reset clears the write position, the drop total and the read position; the
// ring contents are left as they are and need no clearing.
module trace_ring_session_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [63:0] in_session_id,
  input  logic [63:0] in_probe_id,
  input  logic [31:0] in_event_type,
  input  logic [31:0] in_thread_id,
  input  logic [63:0] in_call_id,
  input  logic [63:0] in_timestamp_ns,
  input  logic [5:0]  in_out_limit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [63:0] out_ev_session,
  output logic [63:0] out_ev_probe,
  output logic [31:0] out_ev_type,
  output logic [31:0] out_ev_thread,
  output logic [63:0] out_ev_call,
  output logic [63:0] out_ev_time,
  output logic [5:0]  out_match_count,
  output logic [63:0] out_drop_count,
  output logic        out_last
);
  import trsf_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [63:0]       rp_r;
  logic [63:0]       wp_r;
  logic [63:0]       drop_r;
  logic              drop_inc_r;
  logic [63:0]       diff_r;
  logic [63:0]       want_r;
  logic [LIM_W-1:0]  limit_r;
  logic [LIM_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;

  logic              in_acc;
  logic              push_acc;
  logic              dump_acc;
  logic [63:0]       push_diff;
  logic [CNT_W-1:0]  avail;
  logic [CNT_W-1:0]  walk_len;
  logic              mem_re;
  trsf_event_t       wr_event;
  trsf_event_t       rd_event;
  logic              hit;
  logic              out_ready;
  logic              out_load;
  trsf_result_t      out_res;
  trsf_result_t      load_res;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign push_acc = in_acc && (in_cmd == CMD_PUSH);
  assign dump_acc = in_acc && (in_cmd == CMD_DUMP);

  assign push_diff = wp_r - rp_r;

  assign wr_event.session = in_session_id;
  assign wr_event.probe   = in_probe_id;
  assign wr_event.ev_type = in_event_type;
  assign wr_event.thread  = in_thread_id;
  assign wr_event.call    = in_call_id;
  assign wr_event.time_ns = in_timestamp_ns;

  trsf_ram #(
    .WIDTH($bits(trsf_event_t)),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (push_acc),
    .waddr(wp_r[ADDR_W-1:0]),
    .wdata(wr_event),
    .re   (mem_re),
    .raddr(addr_r),
    .rdata(rd_event)
  );

  // The window holds at most DEPTH entries and is empty when it would start
  // below position zero.
  always_comb begin
    if ((|diff_r[63:CNT_W]) || (diff_r[CNT_W-1:0] > CNT_W'(DEPTH))) begin
      avail = CNT_W'(DEPTH);
    end else begin
      avail = diff_r[CNT_W-1:0];
    end
    if (!(|wp_r[63:CNT_W]) && (wp_r[CNT_W-1:0] < avail)) begin
      walk_len = '0;
    end else begin
      walk_len = avail;
    end
  end

  assign hit = (rd_event.session == want_r);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rem_nxt   = rem_r;
    addr_nxt  = addr_r;
    mem_re    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (dump_acc) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        count_nxt = '0;
        rem_nxt   = walk_len;
        addr_nxt  = wp_r[ADDR_W-1:0] - walk_len[ADDR_W-1:0];
        state_nxt = ST_RD;
      end
      ST_RD: begin
        if ((rem_r == '0) || (count_r == limit_r)) begin
          state_nxt = ST_SUM;
        end else begin
          mem_re    = 1'b1;
          addr_nxt  = addr_r + ADDR_W'(1);
          rem_nxt   = rem_r - CNT_W'(1);
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (!hit) begin
          state_nxt = ST_RD;
        end else if (out_ready) begin
          out_load  = 1'b1;
          count_nxt = count_r + LIM_W'(1);
          state_nxt = ST_RD;
        end
      end
      ST_SUM: begin
        if (out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    load_res = '0;
    if (state_r == ST_SUM) begin
      load_res.kind        = KIND_SUMMARY;
      load_res.match_count = count_r;
      load_res.drop_count  = drop_r;
      load_res.last        = 1'b1;
    end else begin
      load_res.kind = KIND_EVENT;
      load_res.ev   = rd_event;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rp_r       <= '0;
      wp_r       <= '0;
      drop_r     <= '0;
      drop_inc_r <= 1'b0;
      count_r    <= '0;
      rem_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      rem_r      <= rem_nxt;
      drop_inc_r <= push_acc && (|push_diff[63:ADDR_W]);
      drop_r     <= drop_r + {63'd0, drop_inc_r};
      if (cfg_we) begin
        rp_r <= cfg_wdata;
      end
      if (push_acc) begin
        wp_r <= wp_r + 64'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    if (dump_acc) begin
      diff_r  <= wp_r - rp_r;
      want_r  <= in_session_id;
      limit_r <= in_out_limit;
    end
  end

  trsf_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (out_load),
    .load_data(load_res),
    .ready    (out_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_res)
  );

  assign out_kind        = out_res.kind;
  assign out_ev_session  = out_res.ev.session;
  assign out_ev_probe    = out_res.ev.probe;
  assign out_ev_type     = out_res.ev.ev_type;
  assign out_ev_thread   = out_res.ev.thread;
  assign out_ev_call     = out_res.ev.call;
  assign out_ev_time     = out_res.ev.time_ns;
  assign out_match_count = out_res.match_count;
  assign out_drop_count  = out_res.drop_count;
  assign out_last        = out_res.last;

  a_limit_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && state_r != ST_SETUP) |-> (count_r <= limit_r))
    else $error("dump emitted more events than its limit");

  a_window_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> (rem_r <= CNT_W'(DEPTH)))
    else $error("dump window longer than the ring");

  a_summary_ends_dump: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM && out_ready) |=> (out_valid && out_last && state_r == ST_IDLE))
    else $error("summary not sent at end of dump");

  a_dump_starts: assert property (@(posedge clk) disable iff (!rst_n)
    dump_acc |=> (state_r == ST_SETUP))
    else $error("accepted dump did not start a walk");

endmodule

// ===== tb/trace_ring_session_filter_test.sv =====
// Self-checking testbench for the trace ring session filter: random pushes and dumps.
`timescale 1ns / 1ps

module trace_ring_session_filter_test;
  import trsf_pkg::*;

  class ring_dump_scoreboard;
    logic [63:0]  read_pos = '0;
    logic [63:0]  write_pos = '0;
    logic [63:0]  drop_total = '0;
    trsf_event_t  ring [DEPTH];
    trsf_result_t pending_results [$];
    int unsigned  failures = 0;

    function void set_read_position(logic [63:0] value);
      read_pos = value;
    endfunction

    function void note_transfer(logic cmd, trsf_event_t ev, logic [LIM_W-1:0] limit);
      logic [63:0]  avail;
      logic [63:0]  pos;
      int unsigned  count;
      trsf_result_t res;
      if (cmd == CMD_PUSH) begin
        if (write_pos - read_pos >= 64'(DEPTH)) begin
          drop_total = drop_total + 64'd1;
        end
        ring[write_pos[ADDR_W-1:0]] = ev;
        write_pos = write_pos + 64'd1;
      end else begin
        // A read position ahead of the write position gives a huge window that is
        // clamped to the ring size; a window start below zero wraps and walks nothing.
        avail = write_pos - read_pos;
        if (avail > 64'(DEPTH)) begin
          avail = 64'(DEPTH);
        end
        count = 0;
        for (pos = write_pos - avail; pos < write_pos && count < 32'(limit);
             pos = pos + 64'd1) begin
          if (ring[pos[ADDR_W-1:0]].session == ev.session) begin
            res = '0;
            res.kind = KIND_EVENT;
            res.ev = ring[pos[ADDR_W-1:0]];
            pending_results.push_back(res);
            count++;
          end
        end
        res = '0;
        res.kind = KIND_SUMMARY;
        res.match_count = LIM_W'(count);
        res.drop_count = drop_total;
        res.last = 1'b1;
        pending_results.push_back(res);
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        failures++;
        $error("%s: expected 0x%h, got 0x%h", name, want, got);
      end
    endfunction

    function void check_result(trsf_result_t got);
      trsf_result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        $error("Result transfer arrived with no expected result pending.");
        return;
      end
      want = pending_results.pop_front();
      compare_field("kind", 64'(want.kind), 64'(got.kind));
      compare_field("ev_session", want.ev.session, got.ev.session);
      compare_field("ev_probe", want.ev.probe, got.ev.probe);
      compare_field("ev_type", 64'(want.ev.ev_type), 64'(got.ev.ev_type));
      compare_field("ev_thread", 64'(want.ev.thread), 64'(got.ev.thread));
      compare_field("ev_call", want.ev.call, got.ev.call);
      compare_field("ev_time", want.ev.time_ns, got.ev.time_ns);
      compare_field("match_count", 64'(want.match_count), 64'(got.match_count));
      compare_field("drop_count", want.drop_count, got.drop_count);
      compare_field("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [63:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_cmd;
  logic [63:0] in_session_id;
  logic [63:0] in_probe_id;
  logic [31:0] in_event_type;
  logic [31:0] in_thread_id;
  logic [63:0] in_call_id;
  logic [63:0] in_timestamp_ns;
  logic [5:0]  in_out_limit;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [63:0] out_ev_session;
  logic [63:0] out_ev_probe;
  logic [31:0] out_ev_type;
  logic [31:0] out_ev_thread;
  logic [63:0] out_ev_call;
  logic [63:0] out_ev_time;
  logic [5:0]  out_match_count;
  logic [63:0] out_drop_count;
  logic        out_last;

  ring_dump_scoreboard sb = new;
  int unsigned         send_idle_pct = 0;
  int unsigned         stall_pct = 0;
  logic [63:0]         session_pool [4];
  trsf_result_t        seen_result;
  trsf_event_t         seen_event;

  trace_ring_session_filter uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_session_id   (in_session_id),
    .in_probe_id     (in_probe_id),
    .in_event_type   (in_event_type),
    .in_thread_id    (in_thread_id),
    .in_call_id      (in_call_id),
    .in_timestamp_ns (in_timestamp_ns),
    .in_out_limit    (in_out_limit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_ev_session  (out_ev_session),
    .out_ev_probe    (out_ev_probe),
    .out_ev_type     (out_ev_type),
    .out_ev_thread   (out_ev_thread),
    .out_ev_call     (out_ev_call),
    .out_ev_time     (out_ev_time),
    .out_match_count (out_match_count),
    .out_drop_count  (out_drop_count),
    .out_last        (out_last)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen_result.kind = out_kind;
        seen_result.ev.session = out_ev_session;
        seen_result.ev.probe = out_ev_probe;
        seen_result.ev.ev_type = out_ev_type;
        seen_result.ev.thread = out_ev_thread;
        seen_result.ev.call = out_ev_call;
        seen_result.ev.time_ns = out_ev_time;
        seen_result.match_count = out_match_count;
        seen_result.drop_count = out_drop_count;
        seen_result.last = out_last;
        sb.check_result(seen_result);
      end
      if (in_valid && !in_stall) begin
        seen_event.session = in_session_id;
        seen_event.probe = in_probe_id;
        seen_event.ev_type = in_event_type;
        seen_event.thread = in_thread_id;
        seen_event.call = in_call_id;
        seen_event.time_ns = in_timestamp_ns;
        sb.note_transfer(in_cmd, seen_event, in_out_limit);
      end
    end
  end

  function automatic trsf_event_t make_event(logic [63:0] session);
    trsf_event_t ev;
    ev.session = session;
    ev.probe = {$urandom, $urandom};
    ev.ev_type = $urandom;
    ev.thread = $urandom;
    ev.call = {$urandom, $urandom};
    ev.time_ns = {$urandom, $urandom};
    return ev;
  endfunction

  function automatic logic [63:0] pick_session();
    if ($urandom_range(9) == 0) begin
      return {$urandom, $urandom};
    end
    return session_pool[$urandom_range(3)];
  endfunction

  function automatic logic [5:0] pick_limit();
    case ($urandom_range(5))
      0: return 6'd0;
      1: return 6'd63;
      2: return 6'($urandom_range(1, 3));
      default: return 6'($urandom_range(63));
    endcase
  endfunction

  task automatic send_item(input logic cmd, input trsf_event_t ev, input logic [5:0] limit);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd = cmd;
    in_session_id = ev.session;
    in_probe_id = ev.probe;
    in_event_type = ev.ev_type;
    in_thread_id = ev.thread;
    in_call_id = ev.call;
    in_timestamp_ns = ev.time_ns;
    in_out_limit = limit;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Pushes give no result, so after the last expected result the task still lets the
  // bench run on before the block is taken as idle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic write_read_position(input logic [63:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_read_position(value);
  endtask

  initial begin
    logic [63:0] next_pos;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_cmd = CMD_PUSH;
    in_session_id = '0;
    in_probe_id = '0;
    in_event_type = '0;
    in_thread_id = '0;
    in_call_id = '0;
    in_timestamp_ns = '0;
    in_out_limit = '0;
    session_pool[0] = '0;
    session_pool[1] = '1;
    session_pool[2] = {$urandom, $urandom};
    session_pool[3] = {$urandom, $urandom};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_item(CMD_DUMP, make_event(session_pool[0]), 6'd63);
    send_item(CMD_PUSH, '0, 6'd0);
    send_item(CMD_PUSH, '1, 6'd63);
    send_item(CMD_PUSH, make_event(session_pool[2]), pick_limit());
    send_item(CMD_PUSH, make_event(session_pool[1]), pick_limit());
    send_item(CMD_PUSH, make_event(session_pool[2]), pick_limit());
    send_item(CMD_DUMP, make_event(session_pool[1]), 6'd63);
    send_item(CMD_DUMP, '1, 6'd63);
    send_item(CMD_DUMP, '0, 6'd63);
    send_item(CMD_DUMP, make_event(session_pool[2]), 6'd1);
    send_item(CMD_DUMP, make_event(session_pool[2]), 6'd0);
    wait_idle();
    write_read_position(64'd3);
    send_item(CMD_DUMP, make_event(session_pool[2]), 6'd63);
    wait_idle();
    write_read_position('1);
    send_item(CMD_DUMP, make_event(session_pool[2]), 6'd63);
    wait_idle();
    write_read_position(64'd40);
    send_item(CMD_DUMP, make_event(session_pool[1]), 6'd63);

    for (int seg = 0; seg < 8; seg++) begin
      wait_idle();
      case (seg % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 78; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 78; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      next_pos = sb.write_pos;
      case (seg % 6)
        0: write_read_position('0);
        1: write_read_position(next_pos);
        2: write_read_position(next_pos - 64'($urandom_range(40)));
        3: write_read_position('1);
        4: write_read_position(next_pos + 64'($urandom_range(1, 100)));
        default: write_read_position({$urandom, $urandom});
      endcase
      repeat (27) begin
        if ($urandom_range(99) < 15) begin
          send_item(CMD_DUMP, make_event(pick_session()), pick_limit());
        end else begin
          send_item(CMD_PUSH, make_event(pick_session()), 6'($urandom));
        end
      end
    end
    wait_idle();

    if (sb.failures == 0 && sb.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
